// ===== design/clap_pkg.sv =====
// Package for the chapter-list atom parser: request types, parse phases,
// result kinds and fixed constants of the atom layout.
// No dependencies.
package clap_pkg;

    // Default width of the payload length and byte position
    localparam int unsigned LENGTH_BITS_DEF = 20;

    // Atom layout constants
    localparam int unsigned ENTRY_MIN_BYTES = 9;  // time, length byte
    localparam int unsigned COUNT_POS_V0    = 4;  // count byte, version 0
    localparam int unsigned COUNT_POS_V1    = 8;  // count byte, version >= 1
    localparam int unsigned TIME_BYTES      = 8;  // big-endian start time

    // Parse phases
    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_TIME   = 3'd1,
        PH_LEN    = 3'd2,
        PH_TITLE  = 3'd3,
        PH_DONE   = 3'd4
    } t_phase;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_CHAPTER = 2'd0,
        KIND_TITLE   = 2'd1,
        KIND_END     = 2'd2
    } t_kind;

    // One input request: one payload byte
    typedef struct packed {
        logic       restart;
        logic [7:0] data_byte;
    } t_chpl_in;

    // One result request
    typedef struct packed {
        t_kind              item_kind;
        logic [7:0]         chapter_index;
        logic signed [63:0] start_time;
        logic [7:0]         title_length;
        logic [7:0]         title_byte;
        logic               end_of_list;
        logic [7:0]         chapters_found;
    } t_chpl_out;

endpackage

// ===== design/chapter_list_atom_parser.sv =====
// Chapter-list atom parser top level: byte-serial header/entry parse with
// input register, parse state and result register.
// Depends on clap_pkg.
//
// Takes one payload byte per request and returns at most one result per byte:
// a chapter record when an entry's title length byte arrives, one result per
// title byte, and an end marker on the final payload byte when that byte has
// nothing else to report (otherwise the final result carries end_of_list).
// A byte with restart set begins a new payload. The block accepts a byte in
// every cycle; a result passes through the input and result registers, and
// only the consumer holding off the result register slows the byte rate (an
// input stage of one byte and a result register of one result sit between).
// The user must write the payload length through the configuration channel
// only while no byte is in flight; the block itself does not enforce this.
module chapter_list_atom_parser #(
    parameter int unsigned LENGTH_BITS = clap_pkg::LENGTH_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Byte input
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  clap_pkg::t_chpl_in     i_in_data,
    // Result output
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output clap_pkg::t_chpl_out    o_out_data,
    // Payload length register
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [LENGTH_BITS-1:0] i_cfg_data
);
    import clap_pkg::*;

    localparam logic [LENGTH_BITS-1:0] L_ENTRY_MIN  = LENGTH_BITS'(ENTRY_MIN_BYTES);
    localparam logic [LENGTH_BITS-1:0] L_COUNT_V0   = LENGTH_BITS'(COUNT_POS_V0);
    localparam logic [LENGTH_BITS-1:0] L_COUNT_V1   = LENGTH_BITS'(COUNT_POS_V1);
    localparam logic [LENGTH_BITS-1:0] L_ONE        = LENGTH_BITS'(1);
    localparam logic [2:0]             L_TIME_LAST  = 3'(TIME_BYTES - 1);

    // Configuration and pipeline registers
    logic [LENGTH_BITS-1:0] r_len;
    logic                   r_in_valid;
    t_chpl_in               r_in;
    logic                   r_out_valid;
    t_chpl_out              r_out;

    // Parse state
    logic [LENGTH_BITS-1:0] r_pos;
    t_phase                 r_phase;
    logic                   r_vnz;
    logic [7:0]             r_left;
    logic [7:0]             r_cnt;
    logic [63:0]            r_shift;
    logic [7:0]             r_tleft;
    logic [2:0]             r_fbc;

    // Next state
    logic [LENGTH_BITS-1:0] n_pos;
    t_phase                 n_phase;
    logic                   n_vnz;
    logic [7:0]             n_left;
    logic [7:0]             n_cnt;
    logic [63:0]            n_shift;
    logic [7:0]             n_tleft;
    logic [2:0]             n_fbc;

    // Effective state after an optional restart
    logic [LENGTH_BITS-1:0] c_pos;
    t_phase                 c_phase;
    logic                   c_vnz;
    logic [7:0]             c_left;
    logic [7:0]             c_cnt;
    logic [63:0]            c_shift;
    logic [7:0]             c_tleft;
    logic [2:0]             c_fbc;

    logic                   w_out_free;
    logic                   w_proc;
    logic [7:0]             w_byte;
    logic                   w_in_range;
    logic                   w_last;
    logic                   w_parse;
    logic [LENGTH_BITS-1:0] w_rem;
    logic                   w_fits;
    logic [7:0]             w_tleft_dec;
    logic                   n_emit;
    t_chpl_out              n_out;

    // Handshakes
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_proc      = r_in_valid && w_out_free;
    assign o_in_ready  = !r_in_valid || w_out_free;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Apply restart ahead of the parse
    always_comb begin
        if (r_in.restart) begin
            c_pos   = '0;
            c_phase = PH_HEADER;
            c_vnz   = 1'b0;
            c_left  = '0;
            c_cnt   = '0;
            c_shift = '0;
            c_tleft = '0;
            c_fbc   = '0;
        end else begin
            c_pos   = r_pos;
            c_phase = r_phase;
            c_vnz   = r_vnz;
            c_left  = r_left;
            c_cnt   = r_cnt;
            c_shift = r_shift;
            c_tleft = r_tleft;
            c_fbc   = r_fbc;
        end
    end

    // Position checks against the current length
    assign w_byte      = r_in.data_byte;
    assign w_in_range  = c_pos < r_len;
    assign w_last      = w_in_range && ((c_pos + L_ONE) == r_len);
    assign w_parse     = w_in_range && (r_len >= L_ENTRY_MIN);
    assign w_rem       = r_len - c_pos;
    assign w_fits      = (w_byte != 8'd0) && (LENGTH_BITS'(w_byte) < w_rem);
    assign w_tleft_dec = c_tleft - 8'd1;

    // Next parse state
    always_comb begin
        n_pos   = c_pos;
        n_phase = c_phase;
        n_vnz   = c_vnz;
        n_left  = c_left;
        n_cnt   = c_cnt;
        n_shift = c_shift;
        n_tleft = c_tleft;
        n_fbc   = c_fbc;
        n_emit  = 1'b0;
        if (w_in_range) begin
            n_pos = c_pos + L_ONE;
        end
        if (w_parse) begin
            unique case (c_phase)
                PH_HEADER: begin
                    if (c_pos == '0) begin
                        n_vnz = (w_byte != 8'd0);
                    end
                    if (c_pos == (n_vnz ? L_COUNT_V1 : L_COUNT_V0)) begin
                        n_left  = w_byte;
                        n_fbc   = '0;
                        n_phase = PH_TIME;
                    end
                end
                PH_TIME: begin
                    if (c_fbc == '0 && (c_left == '0 || w_rem < L_ENTRY_MIN)) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_shift = {c_shift[55:0], w_byte};
                        if (c_fbc == L_TIME_LAST) begin
                            n_fbc   = '0;
                            n_phase = PH_LEN;
                        end else begin
                            n_fbc = c_fbc + 3'd1;
                        end
                    end
                end
                PH_LEN: begin
                    n_emit = 1'b1;
                    n_cnt  = c_cnt + 8'd1;
                    n_left = c_left - 8'd1;
                    if (w_fits) begin
                        n_tleft = w_byte;
                        n_phase = PH_TITLE;
                    end else begin
                        n_fbc   = '0;
                        n_phase = PH_TIME;
                    end
                end
                PH_TITLE: begin
                    n_emit  = 1'b1;
                    n_tleft = w_tleft_dec;
                    if (w_tleft_dec == '0) begin
                        n_fbc   = '0;
                        n_phase = PH_TIME;
                    end
                end
                default: begin
                    n_phase = PH_DONE;
                end
            endcase
        end
    end

    // Result fields
    always_comb begin
        n_out                = '0;
        n_out.item_kind      = KIND_END;
        n_out.end_of_list    = w_last;
        n_out.chapters_found = n_cnt;
        if (n_emit) begin
            n_out.start_time = c_shift;
            if (c_phase == PH_LEN) begin
                n_out.item_kind     = KIND_CHAPTER;
                n_out.chapter_index = c_cnt;
                n_out.title_length  = w_fits ? w_byte : 8'd0;
            end else begin
                n_out.item_kind     = KIND_TITLE;
                n_out.chapter_index = c_cnt - 8'd1;
                n_out.title_length  = w_tleft_dec;
                n_out.title_byte    = w_byte;
            end
        end
    end

    // Control and parse state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos       <= '0;
            r_phase     <= PH_HEADER;
            r_vnz       <= 1'b0;
            r_left      <= '0;
            r_cnt       <= '0;
            r_shift     <= '0;
            r_tleft     <= '0;
            r_fbc       <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_len <= i_cfg_data;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_out_free) begin
                r_out_valid <= w_proc && (n_emit || w_last);
            end
            if (w_proc) begin
                r_pos   <= n_pos;
                r_phase <= n_phase;
                r_vnz   <= n_vnz;
                r_left  <= n_left;
                r_cnt   <= n_cnt;
                r_shift <= n_shift;
                r_tleft <= n_tleft;
                r_fbc   <= n_fbc;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
        if (w_proc && (n_emit || w_last)) begin
            r_out <= n_out;
        end
    end

    // End markers only ever close the payload
    a_end_marker_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.item_kind == KIND_END |-> o_out_data.end_of_list)
        else $error("end marker without end_of_list");

    // A chapter record counts itself
    a_record_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.item_kind == KIND_CHAPTER |->
            o_out_data.chapters_found == 8'(o_out_data.chapter_index + 8'd1))
        else $error("chapters_found out of step with chapter_index");

    // Title phase always has bytes left
    a_title_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_TITLE |-> r_tleft != 8'd0)
        else $error("title phase with no title bytes left");

endmodule
